### src/nsp_pkg.sv
// Package for the numeric string parser: transaction types, character codes
// and the small decode helpers used by the core.
// No dependencies.
`timescale 1ns / 1ps

package nsp_pkg;

  // Longest string, counted in character positions (range 4 to 15).
  localparam int MAX_CHARS = 11;
  localparam int POS_W     = 4;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_CHARS);

  localparam int VAL_W      = 32;
  localparam int KILO_SHIFT = 10;
  localparam int MEGA_SHIFT = 20;

  // ASCII codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LO_X = 8'h78;
  localparam logic [7:0] CH_UP_X = 8'h58;
  localparam logic [7:0] CH_LO_K = 8'h6B;
  localparam logic [7:0] CH_UP_K = 8'h4B;
  localparam logic [7:0] CH_LO_M = 8'h6D;
  localparam logic [7:0] CH_UP_M = 8'h4D;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_F = 8'h66;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_F = 8'h46;

  typedef struct packed {
    logic [7:0] character;
    logic       first;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             ok;
  } out_t;

  // Core result for one character: fire marks that a result is produced.
  typedef struct packed {
    logic fire;
    out_t data;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } hex_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h = '0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      h.valid  = 1'b1;
      h.nibble = c[3:0];
    end else if (((c >= CH_LO_A) && (c <= CH_LO_F)) ||
                 ((c >= CH_UP_A) && (c <= CH_UP_F))) begin
      // a..f and A..F share the low three bits: 1..6 -> 10..15
      h.valid  = 1'b1;
      h.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return h;
  endfunction

endpackage

### src/nsp_core.sv
// Parser state machine: phase, position and accumulator, advanced by one
// character per enable. Depends on nsp_pkg.
`timescale 1ns / 1ps

module nsp_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  nsp_pkg::in_t  item,
  output nsp_pkg::res_t res
);
  import nsp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DEC,
    PH_LEADZERO,
    PH_HEX,
    PH_DONE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;

  phase_t           ph;
  logic [POS_W-1:0] pos, pos_inc;
  logic [VAL_W-1:0] acc, acc_dec;
  logic [7:0]       c;
  logic             do_dec;
  hex_t             hd;

  always_comb begin
    c   = item.character;
    ph  = phase_r;
    pos = pos_r;
    acc = acc_r;
    if (item.first) begin
      ph  = PH_DEC;
      pos = '0;
      acc = '0;
    end

    pos_inc = pos + POS_W'(1);
    // acc*10 + digit, wrapping at 32 bits
    acc_dec = {acc[VAL_W-4:0], 3'b000} + {acc[VAL_W-2:0], 1'b0} +
              VAL_W'(c[3:0]);
    hd = hex_digit(c);

    phase_nxt = ph;
    pos_nxt   = pos;
    acc_nxt   = acc;
    res       = '0;
    do_dec    = 1'b0;

    case (ph)
      PH_DEC: begin
        do_dec = 1'b1;
      end
      PH_LEADZERO: begin
        if ((c == CH_LO_X) || (c == CH_UP_X)) begin
          phase_nxt = PH_HEX;
          pos_nxt   = POS_W'(2);
          acc_nxt   = '0;
        end else begin
          phase_nxt = PH_DEC;
          do_dec    = 1'b1;
        end
      end
      PH_HEX: begin
        if (c == CH_NUL) begin
          res.fire    = 1'b1;
          res.data.ok = 1'b1;
          res.data.value = acc;
          phase_nxt   = PH_DONE;
        end else if (!hd.valid || (pos >= MAX_POS)) begin
          res.fire  = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          acc_nxt = {acc[VAL_W-5:0], hd.nibble};
          pos_nxt = pos_inc;
        end
      end
      default: begin
      end
    endcase

    if (do_dec) begin
      if (c == CH_NUL) begin
        res.fire = 1'b1;
        res.data.ok = 1'b1;
        res.data.value = acc;
        phase_nxt = PH_DONE;
      end else if (((c == CH_LO_K) || (c == CH_UP_K)) && (pos != '0)) begin
        res.fire = 1'b1;
        res.data.ok = 1'b1;
        res.data.value = acc << KILO_SHIFT;
        phase_nxt = PH_DONE;
      end else if (((c == CH_LO_M) || (c == CH_UP_M)) && (pos != '0)) begin
        res.fire = 1'b1;
        res.data.ok = 1'b1;
        res.data.value = acc << MEGA_SHIFT;
        phase_nxt = PH_DONE;
      end else if (is_dec(c)) begin
        acc_nxt = acc_dec;
        pos_nxt = pos_inc;
        if (pos_inc >= MAX_POS) begin
          res.fire  = 1'b1;
          phase_nxt = PH_DONE;
        end else if ((pos_inc == POS_W'(1)) && (c == CH_0)) begin
          phase_nxt = PH_LEADZERO;
        end else begin
          phase_nxt = PH_DEC;
        end
      end else begin
        res.fire  = 1'b1;
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      acc_r   <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

### src/numeric_string_parser.sv
// Numeric string parser top level: input register, parser core, result register.
// A result passes through the input register and then the result register.
// Throughput: one character per cycle; the input register drains into the
// core whenever the result register is empty or being taken.
// Reset (rst_n low, synchronous) empties both registers and sets the parser idle.
`timescale 1ns / 1ps

module numeric_string_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  nsp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output nsp_pkg::out_t out_data
);
  import nsp_pkg::*;

  // Input register holding one character transaction
  in_t  stage_r;
  logic stage_valid_r;

  // Result register
  out_t out_r;
  logic out_valid_r;

  res_t res;
  logic advance;

  // The staged character is processed once the result slot can take a result;
  // a character that gives no result still waits so that ordering is kept simple.
  assign advance  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;

  nsp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (stage_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= res.fire;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= in_data;
    end
    if (advance && res.fire) begin
      out_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A failed parse always reports value zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.ok) |-> (out_r.value == '0))
    else $error("error result with non-zero value");

  // A result waiting on a stalled output is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !advance)
    else $error("core advanced into a full result register");

  // A staged character is kept until the core consumes it
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && !advance) |=> (stage_valid_r && $stable(stage_r)))
    else $error("staged character lost");

endmodule
